/* hw/rtl/gmdw_pkg.sv */
// shared types and codes for the grid maze walker
// payload beats, register indexes, neighbor codes, controller/datapath link
// no dependencies
package gmdw_pkg;

  // default grid limits
  localparam int ROWS_DEF = 64;
  localparam int COLS_DEF = 64;

  // configuration port
  localparam int CFG_W = 7;
  localparam int IDX_W = 1;
  localparam logic [IDX_W-1:0] REG_GRID_ROWS = 1'd0;
  localparam logic [IDX_W-1:0] REG_GRID_COLS = 1'd1;

  // item operations
  localparam logic OP_STEP    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // neighbor codes, in search order
  localparam logic [1:0] NB_LEFT  = 2'd0;
  localparam logic [1:0] NB_RIGHT = 2'd1;
  localparam logic [1:0] NB_UP    = 2'd2;
  localparam logic [1:0] NB_DOWN  = 2'd3;

  // input beat
  typedef struct packed {
    logic        op;
    logic [15:0] random_word;
  } item_t;

  // result beat
  typedef struct packed {
    logic       edge_added;
    logic [5:0] from_col;
    logic [5:0] from_row;
    logic [5:0] to_col;
    logic [5:0] to_row;
    logic       finished;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic       in_load;
    logic       clr_start;
    logic       clr_step;
    logic       pop;
    logic       cur_load;
    logic [1:0] rd_sel;
    logic       vis_cap;
    logic [1:0] cap_sel;
    logic       pick_load;
    logic       push_cur;
    logic       push_pick;
    logic       res_load;
    logic       res_restart;
    logic       res_empty;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic stack_empty;
    logic any_free;
  } dp_stat_t;

endpackage

/* hw/rtl/grid_maze_dfs_walker_core.sv */
// Maze carver by randomized depth-first search over a MAX_ROWS x MAX_COLS
// cell space, with the grid in use set by grid_rows and grid_cols. One item
// at a time: a step item pops a cell, reads its four neighbors in turn in
// the single-ported visited map and, when one is free, picks it and pushes
// both cells on the single-ported cell stack; a restart item clears the map
// by a sweep of one visited entry per cycle. After reset the same sweep runs
// before the first item is taken; configuration writes are taken at any
// time. The result register lets the next item be accepted while a result
// waits.
// depends on gmdw_pkg, gmdw_ctrl, gmdw_dpath, gmdw_ram
module grid_maze_dfs_walker_core
  import gmdw_pkg::*;
#(
  parameter int MAX_ROWS = ROWS_DEF,
  parameter int MAX_COLS = COLS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0] wr_data,
  input  logic             item_valid,
  output logic             item_stall,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  gmdw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_op      (item.op),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .stat         (stat)
  );

  gmdw_dpath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .item     (item),
    .cmd      (cmd),
    .stat     (stat),
    .result   (result)
  );

`ifndef SYNTHESIS
  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item accepted while previous item in flight");

  // a carved passage leaves the stack non-empty
  a_edge_not_finished: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.edge_added |-> !result.finished)
    else $error("passage reported with empty stack");

  // a passage joins cells that differ in exactly one coordinate
  a_edge_adjacent: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.edge_added |->
      ((result.from_row == result.to_row) != (result.from_col == result.to_col)))
    else $error("passage between non-adjacent cells");
`endif

endmodule

/* hw/rtl/gmdw_ram.sv */
// generic single-port ram, one access a cycle, registered read
// no dependencies
module gmdw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hw/rtl/gmdw_dpath.sv */
// datapath of the maze walker: config registers, visited map, cell stack,
// neighbor test, random pick and the result register
// depends on gmdw_pkg and gmdw_ram
module gmdw_dpath
  import gmdw_pkg::*;
#(
  parameter int MAX_ROWS = ROWS_DEF,
  parameter int MAX_COLS = COLS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0] wr_data,
  input  item_t            item,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  output result_t          result
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RSW   = $clog2(MAX_ROWS + 1);
  localparam int CSW   = $clog2(MAX_COLS + 1);
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNW   = $clog2(CELLS + 1);

  logic [CFG_W-1:0] grid_rows;
  logic [CFG_W-1:0] grid_cols;
  logic [RSW-1:0]   rows_eff;
  logic [CSW-1:0]   cols_eff;
  logic [15:0]      rnd;
  logic [RW-1:0]    cur_row;
  logic [CW-1:0]    cur_col;
  logic [RW-1:0]    pick_row;
  logic [CW-1:0]    pick_col;
  logic [3:0]       free_mask;
  logic [3:0]       inb;
  logic [AW-1:0]    sweep;
  logic [CNW-1:0]   count;
  logic [CNW-1:0]   cnt_m1;
  logic             full;
  logic [2:0]       n_free;
  logic [1:0]       pick_idx;
  logic [1:0]       pick_code;
  logic [RW-1:0]    sel_row;
  logic [CW-1:0]    sel_col;
  logic [RW-1:0]    rd_row;
  logic [CW-1:0]    rd_col;
  result_t          result_next;

  logic                st_we;
  logic [AW-1:0]       st_addr;
  logic [RW+CW-1:0]    st_wdata;
  logic [RW+CW-1:0]    st_rdata;
  logic                vi_we;
  logic [AW-1:0]       vi_addr;
  logic                vi_wdata;
  logic                vi_rdata;

  // 16-bit value mod 3 by base-4 digit sums
  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) t = t - 3'd6;
    if (t >= 3'd3) t = t - 3'd3;
    return t[1:0];
  endfunction

  function automatic logic [RW-1:0] nb_row(input logic [1:0] sel, input logic [RW-1:0] r);
    logic [RW-1:0] o;
    case (sel)
      NB_UP:   o = r - RW'(1);
      NB_DOWN: o = r + RW'(1);
      default: o = r;
    endcase
    return o;
  endfunction

  function automatic logic [CW-1:0] nb_col(input logic [1:0] sel, input logic [CW-1:0] c);
    logic [CW-1:0] o;
    case (sel)
      NB_LEFT:  o = c - CW'(1);
      NB_RIGHT: o = c + CW'(1);
      default:  o = c;
    endcase
    return o;
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(AW'(r) * AW'(MAX_COLS)) + AW'(c);
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= CFG_W'(4);
      grid_cols <= CFG_W'(3);
    end else if (wr_en) begin
      case (wr_index)
        REG_GRID_ROWS: grid_rows <= wr_data;
        REG_GRID_COLS: grid_cols <= wr_data;
        default: ;
      endcase
    end
  end

  // clamp grid size to 1..max
  always_comb begin
    if (grid_rows == '0) begin
      rows_eff = RSW'(1);
    end else if (32'(grid_rows) > 32'(MAX_ROWS)) begin
      rows_eff = RSW'(MAX_ROWS);
    end else begin
      rows_eff = RSW'(grid_rows);
    end
    if (grid_cols == '0) begin
      cols_eff = CSW'(1);
    end else if (32'(grid_cols) > 32'(MAX_COLS)) begin
      cols_eff = CSW'(MAX_COLS);
    end else begin
      cols_eff = CSW'(grid_cols);
    end
  end

  // neighbor bounds of the current cell
  always_comb begin
    inb[NB_LEFT]  = cur_col != '0;
    inb[NB_RIGHT] = (CSW'(cur_col) + CSW'(1)) < cols_eff;
    inb[NB_UP]    = cur_row != '0;
    inb[NB_DOWN]  = (RSW'(cur_row) + RSW'(1)) < rows_eff;
  end

  // random pick among free neighbors
  always_comb begin
    logic [1:0] k;
    k = '0;
    n_free = 3'($countones(free_mask));
    case (n_free)
      3'd1:    pick_idx = 2'd0;
      3'd2:    pick_idx = {1'b0, rnd[0]};
      3'd3:    pick_idx = mod3_16(rnd);
      default: pick_idx = rnd[1:0];
    endcase
    pick_code = NB_LEFT;
    for (int i = 0; i < 4; i++) begin
      if (free_mask[i]) begin
        if (k == pick_idx) pick_code = 2'(i);
        k = k + 2'd1;
      end
    end
    sel_row = nb_row(pick_code, cur_row);
    sel_col = nb_col(pick_code, cur_col);
    rd_row  = nb_row(cmd.rd_sel, cur_row);
    rd_col  = nb_col(cmd.rd_sel, cur_col);
  end

  assign cnt_m1 = count - CNW'(1);
  assign full   = count == CNW'(CELLS);

  // stack port
  always_comb begin
    st_we    = (cmd.clr_step && sweep == '0) ||
               ((cmd.push_cur || cmd.push_pick) && !full);
    st_addr  = count[AW-1:0];
    st_wdata = {pick_row, pick_col};
    if (cmd.clr_step) begin
      st_addr  = '0;
      st_wdata = '0;
    end else if (cmd.pop) begin
      st_addr = cnt_m1[AW-1:0];
    end else if (cmd.push_cur) begin
      st_wdata = {cur_row, cur_col};
    end
  end

  // visited map port
  always_comb begin
    vi_we    = cmd.clr_step || cmd.push_cur;
    vi_wdata = 1'b1;
    vi_addr  = cell_addr(rd_row, rd_col);
    if (cmd.clr_step) begin
      vi_addr  = sweep;
      vi_wdata = sweep == '0;
    end else if (cmd.push_cur) begin
      vi_addr = cell_addr(pick_row, pick_col);
    end
  end

  gmdw_ram #(.WIDTH(RW + CW), .DEPTH(CELLS)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .addr  (st_addr),
    .wdata (st_wdata),
    .rdata (st_rdata)
  );

  gmdw_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
    .clk   (clk),
    .we    (vi_we),
    .addr  (vi_addr),
    .wdata (vi_wdata),
    .rdata (vi_rdata)
  );

  // stack depth and clear sweep
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      count <= CNW'(1);
      sweep <= '0;
    end else begin
      if (cmd.clr_step) sweep <= sweep + AW'(1);
      if (cmd.pop) begin
        count <= cnt_m1;
      end else if ((cmd.push_cur || cmd.push_pick) && !full) begin
        count <= count + CNW'(1);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.in_load) rnd <= item.random_word;
    if (cmd.cur_load) begin
      {cur_row, cur_col} <= st_rdata;
      free_mask          <= '0;
    end
    if (cmd.vis_cap) free_mask[cmd.cap_sel] <= inb[cmd.cap_sel] && !vi_rdata;
    if (cmd.pick_load) begin
      pick_row <= sel_row;
      pick_col <= sel_col;
    end
  end

  // result beat contents
  always_comb begin
    result_next = '0;
    if (cmd.res_empty) begin
      result_next.finished = 1'b1;
    end else if (!cmd.res_restart) begin
      result_next.finished = count == '0;
      if (free_mask != '0) begin
        result_next.edge_added = 1'b1;
        result_next.from_col   = 6'(cur_col);
        result_next.from_row   = 6'(cur_row);
        result_next.to_col     = 6'(pick_col);
        result_next.to_row     = 6'(pick_row);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) result <= result_next;
  end

  assign stat.clr_last    = sweep == AW'(CELLS - 1);
  assign stat.stack_empty = count == '0;
  assign stat.any_free    = free_mask != '0;

endmodule

/* hw/rtl/gmdw_ctrl.sv */
// controller of the maze walker: sequences clear sweep, pop, neighbor
// reads, pick, pushes and result hand-off
// depends on gmdw_pkg
module gmdw_ctrl
  import gmdw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  logic     item_op,
  output logic     item_stall,
  output logic     result_valid,
  input  logic     result_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_POP, S_CUR, S_NB, S_NBLAST, S_PICK, S_PUSH1, S_PUSH2, S_FIN
  } state_t;

  state_t     state;
  logic [1:0] nb_k;
  logic       reply;
  logic       kind_restart;
  logic       kind_empty;
  logic       accept;

  assign item_stall = state != S_IDLE;
  assign accept     = state == S_IDLE && item_valid;

  // datapath commands
  always_comb begin
    cmd             = '0;
    cmd.in_load     = accept;
    cmd.clr_start   = accept && item_op == OP_RESTART;
    cmd.clr_step    = state == S_CLEAR;
    cmd.pop         = state == S_POP;
    cmd.cur_load    = state == S_CUR;
    cmd.rd_sel      = nb_k;
    cmd.vis_cap     = (state == S_NB && nb_k != NB_LEFT) || state == S_NBLAST;
    cmd.cap_sel     = nb_k - 2'd1;
    cmd.pick_load   = state == S_PICK;
    cmd.push_cur    = state == S_PUSH1;
    cmd.push_pick   = state == S_PUSH2;
    cmd.res_load    = state == S_FIN && (!result_valid || !result_stall);
    cmd.res_restart = kind_restart;
    cmd.res_empty   = kind_empty;
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      nb_k         <= NB_LEFT;
      reply        <= 1'b0;
      kind_restart <= 1'b0;
      kind_empty   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (stat.clr_last) state <= reply ? S_FIN : S_IDLE;
        end
        S_IDLE: begin
          if (item_valid) begin
            if (item_op == OP_RESTART) begin
              reply        <= 1'b1;
              kind_restart <= 1'b1;
              kind_empty   <= 1'b0;
              state        <= S_CLEAR;
            end else if (stat.stack_empty) begin
              kind_restart <= 1'b0;
              kind_empty   <= 1'b1;
              state        <= S_FIN;
            end else begin
              kind_restart <= 1'b0;
              kind_empty   <= 1'b0;
              state        <= S_POP;
            end
          end
        end
        S_POP: state <= S_CUR;
        S_CUR: begin
          nb_k  <= NB_LEFT;
          state <= S_NB;
        end
        S_NB: begin
          nb_k <= nb_k + 2'd1;
          if (nb_k == NB_DOWN) state <= S_NBLAST;
        end
        S_NBLAST: state <= S_PICK;
        S_PICK: state <= stat.any_free ? S_PUSH1 : S_FIN;
        S_PUSH1: state <= S_PUSH2;
        S_PUSH2: state <= S_FIN;
        S_FIN: begin
          if (cmd.res_load) begin
            reply <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // output beat held until taken
      if (cmd.res_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
